FILE: sv/tce_pkg.sv
`timescale 1ns / 1ps

package tce_pkg;

    // Default geometry
    localparam int ROWS_DEF       = 25;
    localparam int COLS_DEF       = 80;
    localparam int FIRST_LINE_DEF = 1;

    // Front-to-back queue depth
    localparam int Q_DEPTH = 2;

    // Control characters
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLINK = 2'd0;
    localparam logic [1:0] CFG_BG    = 2'd1;
    localparam logic [1:0] CFG_FG    = 2'd2;

    localparam logic [3:0] FG_RESET = 4'd10;

    typedef enum logic [2:0] {
        K_PUT,
        K_BS,
        K_TAB,
        K_LF,
        K_FF,
        K_CR,
        K_READ,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SWEEP
    } t_state;

endpackage

FILE: sv/tce_in_if.sv
`timescale 1ns / 1ps

interface tce_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;

    modport source (output valid, opcode, char_code, read_row, read_column, input ready);
    modport sink   (input valid, opcode, char_code, read_row, read_column, output ready);
endinterface

FILE: sv/tce_out_if.sv
`timescale 1ns / 1ps

interface tce_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_linear;
    logic [7:0]  cell_character;
    logic [7:0]  cell_attribute;

    modport source (output valid, cursor_row, cursor_column, cursor_linear,
                    cell_character, cell_attribute, input ready);
    modport sink   (input valid, cursor_row, cursor_column, cursor_linear,
                    cell_character, cell_attribute, output ready);
endinterface

FILE: sv/tce_front.sv
`timescale 1ns / 1ps

module tce_front #(
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int COLS = tce_pkg::COLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tce_in_if.sink          in_ch,
    input  logic            i_init_done,
    output logic            o_q_valid,
    output tce_pkg::t_entry o_q_entry,
    input  logic            i_q_ready
);

    localparam int QAW = $clog2(tce_pkg::Q_DEPTH);
    localparam int QCW = $clog2(tce_pkg::Q_DEPTH + 1);

    tce_pkg::t_entry r_q [tce_pkg::Q_DEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;

    tce_pkg::t_entry entry;
    logic            push;
    logic            pop;

    // Classify the incoming word
    always_comb begin
        entry.ch   = in_ch.char_code;
        entry.row  = in_ch.read_row;
        entry.col  = in_ch.read_column;
        entry.kind = tce_pkg::K_PUT;
        if (in_ch.opcode == tce_pkg::OP_READ) begin
            if ((7'(in_ch.read_row) < 7'(ROWS)) && (8'(in_ch.read_column) < 8'(COLS))) begin
                entry.kind = tce_pkg::K_READ;
            end else begin
                entry.kind = tce_pkg::K_NONE;
            end
        end else begin
            case (in_ch.char_code)
                tce_pkg::CH_BS:  entry.kind = tce_pkg::K_BS;
                tce_pkg::CH_TAB: entry.kind = tce_pkg::K_TAB;
                tce_pkg::CH_LF:  entry.kind = tce_pkg::K_LF;
                tce_pkg::CH_FF:  entry.kind = tce_pkg::K_FF;
                tce_pkg::CH_CR:  entry.kind = tce_pkg::K_CR;
                default:         entry.kind = tce_pkg::K_PUT;
            endcase
        end
    end

    assign in_ch.ready = i_init_done && (r_cnt != QCW'(tce_pkg::Q_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_entry   = r_q[r_rp];
    assign pop         = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/tce_back.sv
`timescale 1ns / 1ps

module tce_back #(
    parameter int ROWS       = tce_pkg::ROWS_DEF,
    parameter int COLS       = tce_pkg::COLS_DEF,
    parameter int FIRST_LINE = tce_pkg::FIRST_LINE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tce_pkg::t_entry i_q_entry,
    output logic            o_q_ready,
    output logic            o_init_done,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [3:0]      i_cfg_wdata,
    tce_out_if.source       out_ch
);

    localparam int NCELLS    = ROWS * COLS;
    localparam int AW        = $clog2(NCELLS);
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLS);
    localparam int HOME      = (FIRST_LINE < ROWS) ? FIRST_LINE : ROWS - 1;
    localparam int SCR_ROW   = (FIRST_LINE < ROWS - 1) ? FIRST_LINE : ROWS - 1;

    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] SCR_START = AW'(SCR_ROW * COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [RW-1:0] HOME_ROW  = RW'(HOME);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

    logic [15:0]     r_mem [NCELLS];
    logic [15:0]     r_rd_data;

    tce_pkg::t_state r_state;
    tce_pkg::t_state n_state;
    logic            r_init_done;

    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   n_row;
    logic [CW-1:0]   n_col;

    logic            r_blink;
    logic [2:0]      r_bg;
    logic [3:0]      r_fg;

    logic [AW-1:0]   r_ptr;
    logic            r_copy_mode;
    logic [15:0]     r_fill;
    logic            r_wb_valid;
    logic [AW-1:0]   r_wb_addr;
    logic            r_wb_copy;

    logic            r_out_valid;
    logic [4:0]      r_out_row;
    logic [6:0]      r_out_col;
    logic [10:0]     r_out_lin;
    logic [7:0]      r_out_ch;
    logic [7:0]      r_out_at;

    logic [7:0]      attr;
    logic [15:0]     blank;
    logic            take;
    logic            start_scroll;
    logic            start_clear;
    logic            put_we;
    logic            copy_now;
    logic            out_load;
    logic [7:0]      out_ch_v;
    logic [7:0]      out_at_v;
    logic [AW-1:0]   cur_addr;
    logic [AW-1:0]   lin;
    logic [CW:0]     tab_col;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    assign attr     = {r_blink, r_bg, r_fg};
    assign blank    = {attr, tce_pkg::CH_SPACE};
    assign cur_addr = AW'(r_row) * COLS_A + AW'(r_col);
    assign copy_now = r_copy_mode && (r_ptr < LAST_BASE);
    assign tab_col  = ({1'b0, r_col} + (CW+1)'(8)) & ~(CW+1)'(7);

    // Pop only when nothing is in flight and the output register is free
    assign o_q_ready   = (r_state == tce_pkg::S_IDLE) && !r_wb_valid
                         && (!r_out_valid || out_ch.ready);
    assign take        = o_q_ready && i_q_valid;
    assign o_init_done = r_init_done;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tce_pkg::S_IDLE: begin
                if (take && (i_q_entry.kind == tce_pkg::K_READ)) begin
                    n_state = tce_pkg::S_READ;
                end else if (start_scroll || start_clear) begin
                    n_state = tce_pkg::S_SWEEP;
                end
            end
            tce_pkg::S_READ: begin
                n_state = tce_pkg::S_IDLE;
            end
            tce_pkg::S_SWEEP: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = tce_pkg::S_IDLE;
                end
            end
            default: n_state = tce_pkg::S_IDLE;
        endcase
    end

    // Cursor update, memory port and result selection
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        start_scroll = 1'b0;
        start_clear  = 1'b0;
        put_we       = 1'b0;
        out_load     = 1'b0;
        out_ch_v     = '0;
        out_at_v     = '0;
        mem_raddr    = r_ptr;
        case (r_state)
            tce_pkg::S_IDLE: begin
                if (i_q_entry.kind == tce_pkg::K_READ) begin
                    mem_raddr = AW'(i_q_entry.row) * COLS_A + AW'(i_q_entry.col);
                end
                if (take) begin
                    out_load = (i_q_entry.kind != tce_pkg::K_READ);
                    case (i_q_entry.kind)
                        tce_pkg::K_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        tce_pkg::K_TAB: begin
                            if (tab_col >= (CW+1)'(COLS)) begin
                                n_col = LAST_COL;
                            end else begin
                                n_col = tab_col[CW-1:0];
                            end
                        end
                        tce_pkg::K_CR: begin
                            n_col = '0;
                        end
                        tce_pkg::K_LF: begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                start_scroll = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        tce_pkg::K_FF: begin
                            n_row       = HOME_ROW;
                            n_col       = '0;
                            start_clear = 1'b1;
                        end
                        tce_pkg::K_PUT: begin
                            put_we = 1'b1;
                            if (r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    start_scroll = 1'b1;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tce_pkg::S_READ: begin
                out_load = 1'b1;
                out_ch_v = r_rd_data[7:0];
                out_at_v = r_rd_data[15:8];
            end
            tce_pkg::S_SWEEP: begin
                if (copy_now) begin
                    mem_raddr = r_ptr + COLS_A;
                end
            end
            default: begin
            end
        endcase
    end

    assign lin = AW'(n_row) * COLS_A + AW'(n_col);

    // Sweep write-back has the port; a cell write only happens when it is idle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {attr, i_q_entry.ch};
        if (r_wb_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_wb_addr;
            mem_wdata = r_wb_copy ? r_rd_data : r_fill;
        end else if (put_we) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row <= 5'(n_row);
            r_out_col <= 7'(n_col);
            r_out_lin <= 11'(lin);
            r_out_ch  <= out_ch_v;
            r_out_at  <= out_at_v;
        end
        r_wb_addr <= r_ptr;
        r_wb_copy <= copy_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tce_pkg::S_SWEEP;
            r_init_done <= 1'b0;
            r_row       <= HOME_ROW;
            r_col       <= '0;
            r_blink     <= 1'b0;
            r_bg        <= '0;
            r_fg        <= tce_pkg::FG_RESET;
            r_ptr       <= '0;
            r_copy_mode <= 1'b0;
            r_fill      <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_wb_valid <= (r_state == tce_pkg::S_SWEEP);
            if ((r_state == tce_pkg::S_SWEEP) && (r_ptr == LAST_CELL)) begin
                r_init_done <= 1'b1;
            end
            if (r_state == tce_pkg::S_SWEEP) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (start_scroll) begin
                r_ptr       <= SCR_START;
                r_copy_mode <= 1'b1;
                r_fill      <= blank;
            end else if (start_clear) begin
                r_ptr       <= '0;
                r_copy_mode <= 1'b0;
                r_fill      <= blank;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tce_pkg::CFG_BLINK: r_blink <= i_cfg_wdata[0];
                    tce_pkg::CFG_BG:    r_bg    <= i_cfg_wdata[2:0];
                    tce_pkg::CFG_FG:    r_fg    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign out_ch.valid          = r_out_valid;
    assign out_ch.cursor_row     = r_out_row;
    assign out_ch.cursor_column  = r_out_col;
    assign out_ch.cursor_linear  = r_out_lin;
    assign out_ch.cell_character = r_out_ch;
    assign out_ch.cell_attribute = r_out_at;

endmodule

FILE: sv/text_console_char_engine.sv
`timescale 1ns / 1ps
// Result path: front queue, then output register; cell reads add the memory read.
// Throughput: one word per cycle for cursor moves and printable characters unless the
//   output stalls; a cell read holds the back end through S_READ; a scroll walks
//   (ROWS-FIRST_LINE)*COLS cells and a form feed ROWS*COLS cells, one per cycle, plus
//   a write-back stage.
// Reset: synchronous, active low; afterwards the screen memory is cleared one cell
//   a cycle (all ROWS*COLS cells, 2000 by default) while no word is accepted.

module text_console_char_engine #(
    parameter int ROWS       = tce_pkg::ROWS_DEF,
    parameter int COLS       = tce_pkg::COLS_DEF,
    parameter int FIRST_LINE = tce_pkg::FIRST_LINE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tce_in_if.sink     i_in,
    tce_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_wdata
);

    // Queue between the classifier and the screen engine
    logic            q_valid;
    logic            q_ready;
    tce_pkg::t_entry q_entry;
    logic            init_done;

    // Front: classify each word as a control code, a cell write, a read or an
    // off-screen read, and hold it in a two-entry queue so the input keeps moving,
    // until the queue fills, while the back end is busy scrolling or clearing.
    tce_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_in),
        .i_init_done (init_done),
        .o_q_valid   (q_valid),
        .o_q_entry   (q_entry),
        .i_q_ready   (q_ready)
    );

    // Back: owns the cursor, the attribute registers and the screen memory.
    // Cursor moves finish in the pop cycle; scroll and clear run as a sweep
    // through the memory, with a write-back stage behind the read.
    tce_back #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .FIRST_LINE (FIRST_LINE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_ready   (q_ready),
        .o_init_done (init_done),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .out_ch      (o_out)
    );

endmodule

FILE: sv/tce_chk.sv
`timescale 1ns / 1ps

module tce_chk #(
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int COLS = tce_pkg::COLS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_row,
    input logic [6:0]  out_col,
    input logic [10:0] out_lin,
    input logic [7:0]  out_ch,
    input logic [7:0]  out_at
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_row, out_col, out_lin,
                                                          out_ch, out_at}))
        else $error("result word changed while stalled");

    // The clearing pass after reset blocks input
    a_init_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !in_ready)
        else $error("input accepted during clearing pass");

    // Linear cursor agrees with row and column
    a_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_lin == 11'(32'(out_col) + 32'(out_row) * COLS))
        else $error("linear cursor mismatch");

    // Cursor stays on screen
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (32'(out_row) < ROWS) && (32'(out_col) < COLS))
        else $error("cursor off screen");

endmodule

bind text_console_char_engine tce_chk #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tce_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_row   (o_out.cursor_row),
    .out_col   (o_out.cursor_column),
    .out_lin   (o_out.cursor_linear),
    .out_ch    (o_out.cell_character),
    .out_at    (o_out.cell_attribute)
);

FILE: tb/sv/tce_checker.sv
`timescale 1ns / 1ps

module tce_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tce_in_if          i_in,
    tce_out_if         i_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_wdata,
    output int         o_errors,
    output int         o_pending
);

    localparam int GRID_ROWS = tce_pkg::ROWS_DEF;
    localparam int GRID_COLS = tce_pkg::COLS_DEF;
    localparam int HOME_ROW  = (tce_pkg::FIRST_LINE_DEF < GRID_ROWS)
                               ? tce_pkg::FIRST_LINE_DEF : GRID_ROWS - 1;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] linear;
        logic [7:0]  ch;
        logic [7:0]  attr;
    } t_cursor_report;

    t_cursor_report expected_reports[$];

    logic [15:0] screen [GRID_ROWS * GRID_COLS];
    int          cur_row;
    int          cur_col;
    logic        blink;
    logic [2:0]  bg_color;
    logic [3:0]  fg_color;

    function automatic logic [7:0] cur_attr();
        return {blink, bg_color, fg_color};
    endfunction

    // Move one row down; at the bottom, shift rows below the home row up and blank the last.
    task automatic line_down();
        if (cur_row + 1 >= GRID_ROWS) begin
            cur_row = GRID_ROWS - 1;
            for (int r = tce_pkg::FIRST_LINE_DEF; r + 1 < GRID_ROWS; r++) begin
                for (int c = 0; c < GRID_COLS; c++) begin
                    screen[r * GRID_COLS + c] = screen[(r + 1) * GRID_COLS + c];
                end
            end
            for (int c = 0; c < GRID_COLS; c++) begin
                screen[(GRID_ROWS - 1) * GRID_COLS + c] = {cur_attr(), tce_pkg::CH_SPACE};
            end
        end else begin
            cur_row++;
        end
    endtask

    task automatic predict_word(input logic op, input logic [7:0] ch, input logic [4:0] rrow,
                                input logic [6:0] rcol, output t_cursor_report rep);
        logic [15:0] rd_cell;
        rd_cell = '0;
        if (op == tce_pkg::OP_CHAR) begin
            case (ch)
                tce_pkg::CH_BS: begin
                    if (cur_col > 0) cur_col--;
                end
                tce_pkg::CH_TAB: begin
                    cur_col = 8 * (cur_col / 8 + 1);
                    if (cur_col >= GRID_COLS) cur_col = GRID_COLS - 1;
                end
                tce_pkg::CH_LF: begin
                    line_down();
                    cur_col = 0;
                end
                tce_pkg::CH_FF: begin
                    foreach (screen[i]) screen[i] = {cur_attr(), tce_pkg::CH_SPACE};
                    cur_row = HOME_ROW;
                    cur_col = 0;
                end
                tce_pkg::CH_CR: begin
                    cur_col = 0;
                end
                default: begin
                    screen[cur_row * GRID_COLS + cur_col] = {cur_attr(), ch};
                    cur_col++;
                    if (cur_col >= GRID_COLS) begin
                        cur_col = 0;
                        line_down();
                    end
                end
            endcase
        end else if (rrow < GRID_ROWS && rcol < GRID_COLS) begin
            rd_cell = screen[rrow * GRID_COLS + rcol];
        end
        rep.row    = 5'(cur_row);
        rep.col    = 7'(cur_col);
        rep.linear = 11'(cur_col + cur_row * GRID_COLS);
        rep.ch     = rd_cell[7:0];
        rep.attr   = rd_cell[15:8];
    endtask

    function automatic int field_bad(string name, int want, int got);
        if (want == got) return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_cursor_report got;
        t_cursor_report want;
        if (!i_rst_n) begin
            foreach (screen[i]) screen[i] = '0;
            cur_row  = HOME_ROW;
            cur_col  = 0;
            blink    = 1'b0;
            bg_color = 3'd0;
            fg_color = tce_pkg::FG_RESET;
            expected_reports.delete();
            o_errors = 0;
        end else begin
            // Check the outgoing word first: it can never belong to a word accepted this edge.
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.cursor_row, i_out.cursor_column, i_out.cursor_linear,
                        i_out.cell_character, i_out.cell_attribute};
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, got);
                    o_errors++;
                end else begin
                    want = expected_reports.pop_front();
                    o_errors += field_bad("cursor_row", want.row, got.row);
                    o_errors += field_bad("cursor_column", want.col, got.col);
                    o_errors += field_bad("cursor_linear", want.linear, got.linear);
                    o_errors += field_bad("cell_character", want.ch, got.ch);
                    o_errors += field_bad("cell_attribute", want.attr, got.attr);
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.opcode, i_in.char_code, i_in.read_row, i_in.read_column,
                             want);
                expected_reports.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tce_pkg::CFG_BLINK: blink    = i_cfg_wdata[0];
                    tce_pkg::CFG_BG:    bg_color = i_cfg_wdata[2:0];
                    tce_pkg::CFG_FG:    fg_color = i_cfg_wdata;
                    default:   ;
                endcase
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int GRID_ROWS    = tce_pkg::ROWS_DEF;
    localparam int GRID_COLS    = tce_pkg::COLS_DEF;
    // A scroll or a form feed walks at most every cell once; allow that plus margin.
    localparam int DRAIN_CYCLES = GRID_ROWS * GRID_COLS + 100;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES  = 3000;
    // Cycles with no word moving on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_WORDS  = 125;
    localparam int NUM_PHASES   = 5;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [3:0] cfg_wdata;
    int         errors;
    int         pending;

    // Idle percentages, set per phase by the stimulus process.
    int idle_pct;
    int stall_pct;
    // Bump to ask the receiver for one long hold-off.
    int hold_requests;

    tce_in_if  word_in ();
    tce_out_if word_out ();

    text_console_char_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (word_in),
        .o_out       (word_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    tce_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (word_in),
        .i_out       (word_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, or hold ready low for a long stretch when asked.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        word_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                word_out.ready <= 1'b0;
            end else begin
                word_out.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one word, idling first at random; return at the edge that takes it.
    task automatic send_word(input logic op, input logic [7:0] ch, input logic [4:0] row,
                             input logic [6:0] col);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            word_in.valid <= 1'b0;
            @(negedge clk);
        end
        word_in.valid       <= 1'b1;
        word_in.opcode      <= op;
        word_in.char_code   <= ch;
        word_in.read_row    <= row;
        word_in.read_column <= col;
        do @(posedge clk); while (!word_in.ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_colors(input logic blink, input logic [2:0] bg, input logic [3:0] fg);
        write_reg(tce_pkg::CFG_BLINK, {3'b000, blink});
        write_reg(tce_pkg::CFG_BG, {1'b0, bg});
        write_reg(tce_pkg::CFG_FG, fg);
    endtask

    // Drop valid, wait for every result, then let any scroll or clear sweep finish.
    task automatic settle();
        @(negedge clk);
        word_in.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly text with line breaks and cursor moves; a share of cell reads, some off-screen.
    task automatic send_random_word();
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 30) begin
            if ($urandom_range(99) < 85)
                send_word(tce_pkg::OP_READ, 8'($urandom), 5'($urandom_range(GRID_ROWS - 1)),
                          7'($urandom_range(GRID_COLS - 1)));
            else
                send_word(tce_pkg::OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
            pick = $urandom_range(199);
            // Keep form feeds rare so the cursor gets down to the bottom and scrolls.
            if (pick < 1)       ch = tce_pkg::CH_FF;
            else if (pick < 28) ch = tce_pkg::CH_LF;
            else if (pick < 38) ch = tce_pkg::CH_BS;
            else if (pick < 50) ch = tce_pkg::CH_TAB;
            else if (pick < 58) ch = tce_pkg::CH_CR;
            else if (pick < 74) ch = 8'($urandom);
            else                ch = 8'($urandom_range(126, 32));
            send_word(tce_pkg::OP_CHAR, ch, 5'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        word_in.valid       = 1'b0;
        word_in.opcode      = tce_pkg::OP_CHAR;
        word_in.char_code   = 8'h00;
        word_in.read_row    = 5'd0;
        word_in.read_column = 7'd0;
        cfg_we        = 1'b0;
        cfg_idx       = tce_pkg::CFG_BLINK;
        cfg_wdata     = 4'd0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        rst_n         = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: cleared screen, off-screen reads, odd bytes, cursor edges.
        send_word(tce_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
        send_word(tce_pkg::OP_READ, 8'hff, 5'd31, 7'd127);
        send_word(tce_pkg::OP_READ, 8'h00, 5'd25, 7'd80);
        send_word(tce_pkg::OP_CHAR, tce_pkg::CH_BS, 5'd0, 7'd0);   // hold at column 0
        send_word(tce_pkg::OP_CHAR, 8'h00, 5'd0, 7'd0);
        send_word(tce_pkg::OP_CHAR, 8'hff, 5'd0, 7'd0);
        send_word(tce_pkg::OP_CHAR, 8'h0f, 5'd0, 7'd0);
        send_word(tce_pkg::OP_CHAR, 8'h0e, 5'd0, 7'd0);
        send_word(tce_pkg::OP_CHAR, tce_pkg::CH_BS, 5'd0, 7'd0);   // step back without erasing
        send_word(tce_pkg::OP_CHAR, tce_pkg::CH_CR, 5'd0, 7'd0);
        // Tab stops up to the last one, then clamp to the last column.
        repeat (10) send_word(tce_pkg::OP_CHAR, tce_pkg::CH_TAB, 5'd0, 7'd0);
        send_word(tce_pkg::OP_CHAR, 8'h5a, 5'd0, 7'd0);            // write at last column, wrap
        send_word(tce_pkg::OP_CHAR, tce_pkg::CH_LF, 5'd0, 7'd0);
        send_word(tce_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
        send_word(tce_pkg::OP_CHAR, tce_pkg::CH_FF, 5'd0, 7'd0);
        send_word(tce_pkg::OP_READ, 8'h00, 5'd1, 7'd0);            // blank after form feed

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Change attributes only with the block drained.
            if (phase > 0) settle();
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_colors(1'b1, 3'd7, 4'd15);
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    set_colors(1'b0, 3'd0, 4'd0);
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                3: begin
                    set_colors(1'b1, 3'($urandom), 4'($urandom));
                    idle_pct  = 19;
                    stall_pct = 19;
                end
                default: begin
                    // Back the block up: receiver holds off while words keep coming.
                    set_colors(1'($urandom), 3'($urandom), 4'($urandom));
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_requests++;
                end
            endcase
            repeat (PHASE_WORDS) send_random_word();
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
